/* rtl/scbc_pkg.sv */
`default_nettype none
// ============================================================================
// scbc_pkg - shared types and constants of the spline to Bezier converter
// Holds the tension format, the rounding constants, the Bezier point kind
// codes and the per-segment flag group passed from the front to the back.
// ============================================================================
package scbc_pkg;

    // Tension register: tension / 3 as unsigned Q0.16, 15 bits wide.
    localparam int K_BITS = 15;
    localparam logic [K_BITS-1:0] K_MAX   = 15'd21845;
    localparam logic [K_BITS-1:0] K_RESET = 15'd10923;

    // Offsets are (k * diff + half) / 2^FRAC_BITS, truncated toward zero.
    localparam int FRAC_BITS  = 16;
    localparam int ROUND_HALF = 32768;

    // Width of the tuser field on the result side: point kind, curve done.
    localparam int USER_W = 3;

    typedef enum logic [1:0] {
        KIND_ANCHOR = 2'd0,
        KIND_CTRL1  = 2'd1,
        KIND_CTRL2  = 2'd2,
        KIND_END    = 2'd3
    } point_kind_t;

    // Flags that travel with one segment.
    typedef struct packed {
        logic anchor;    // emit the start anchor before the segment
        logic run_last;  // the segment end closes the results of its item
        logic done;      // the segment end closes the whole curve
    } seg_flags_t;

    // Width of one packed segment job: two points, four differences, flags.
    function automatic int job_width(input int coord_bits);
        return 8 * coord_bits + 4 + $bits(seg_flags_t);
    endfunction

endpackage
`default_nettype wire

/* rtl/scbc_front.sv */
`default_nettype none
// ============================================================================
// scbc_front - point window and segment classifier
// Accepts polyline points, keeps the three previous points and turns each
// point into zero, one or two segment jobs with precomputed differences.
// ============================================================================
module scbc_front #(
    parameter int COORD_BITS = 16,
    localparam int JOB_W = scbc_pkg::job_width(COORD_BITS)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] in_x,
    input  wire logic signed [COORD_BITS-1:0] in_y,
    input  wire logic                         in_final,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output logic [JOB_W-1:0]                  push_job
);
    import scbc_pkg::*;

    localparam int CB = COORD_BITS;

    typedef struct packed {
        seg_flags_t            flags;
        logic signed [CB:0]    dby;
        logic signed [CB:0]    dbx;
        logic signed [CB:0]    day;
        logic signed [CB:0]    dax;
        logic signed [CB-1:0]  p2y;
        logic signed [CB-1:0]  p2x;
        logic signed [CB-1:0]  p1y;
        logic signed [CB-1:0]  p1x;
    } job_t;

    // Builds a segment p0..p3; the back needs p1, p2, p2 - p0 and p3 - p1.
    function automatic job_t mk_job(
        input logic signed [CB-1:0] ax, input logic signed [CB-1:0] ay,
        input logic signed [CB-1:0] bx, input logic signed [CB-1:0] by,
        input logic signed [CB-1:0] cx, input logic signed [CB-1:0] cy,
        input logic signed [CB-1:0] ex, input logic signed [CB-1:0] ey,
        input logic anc, input logic rl, input logic dn);
        job_t j;
        j.p1x = bx;
        j.p1y = by;
        j.p2x = cx;
        j.p2y = cy;
        j.dax = {cx[CB-1], cx} - {ax[CB-1], ax};
        j.day = {cy[CB-1], cy} - {ay[CB-1], ay};
        j.dbx = {ex[CB-1], ex} - {bx[CB-1], bx};
        j.dby = {ey[CB-1], ey} - {by[CB-1], by};
        j.flags.anchor   = anc;
        j.flags.run_last = rl;
        j.flags.done     = dn;
        return j;
    endfunction

    logic signed [CB-1:0] wx_reg [3];
    logic signed [CB-1:0] wy_reg [3];
    logic [1:0]           seen_reg;
    logic [1:0]           seen_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    job_t                 pend_job_reg;
    job_t                 job1;
    job_t                 job2;
    logic                 need1;
    logic                 need2;
    logic                 accept;
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;

    assign in_ready = !pend_valid_reg && push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ax    = (seen_reg == 2'd2) ? wx_reg[1] : wx_reg[0];
        ay    = (seen_reg == 2'd2) ? wy_reg[1] : wy_reg[0];
        need1 = 1'b0;
        need2 = 1'b0;
        job1  = '0;
        job2  = '0;
        unique case (seen_reg) inside
            2'd0:
            begin
                need1 = 1'b0;
            end
            2'd1:
            begin
                // Two-point curve: both neighbours repeat the end points.
                need1 = in_final;
                job1  = mk_job(wx_reg[2], wy_reg[2], wx_reg[2], wy_reg[2],
                               in_x, in_y, in_x, in_y, 1'b1, 1'b1, 1'b1);
            end
            2'd2, 2'd3:
            begin
                need1 = 1'b1;
                job1  = mk_job(ax, ay, wx_reg[1], wy_reg[1], wx_reg[2], wy_reg[2],
                               in_x, in_y, (seen_reg == 2'd2), !in_final, 1'b0);
                // Closing segment of the curve with the end point repeated.
                need2 = in_final;
                job2  = mk_job(wx_reg[1], wy_reg[1], wx_reg[2], wy_reg[2],
                               in_x, in_y, in_x, in_y, 1'b0, 1'b1, 1'b1);
            end
            default:
            begin
                need1 = 1'b0;
            end
        endcase
    end

    assign push_valid = pend_valid_reg || (accept && need1);
    assign push_job   = pend_valid_reg ? pend_job_reg : job1;

    always_comb
    begin
        seen_next = seen_reg;
        if (accept)
        begin
            if (in_final)
                seen_next = 2'd0;
            else if (seen_reg != 2'd3)
                seen_next = seen_reg + 2'd1;
        end
        pend_valid_next = pend_valid_reg;
        if (pend_valid_reg && push_ready)
            pend_valid_next = 1'b0;
        else if (accept && need2)
            pend_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 2'd0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg       <= seen_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                wx_reg[i] <= '0;
                wy_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            wx_reg[0] <= wx_reg[1];
            wy_reg[0] <= wy_reg[1];
            wx_reg[1] <= wx_reg[2];
            wy_reg[1] <= wy_reg[2];
            wx_reg[2] <= in_x;
            wy_reg[2] <= in_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && need2)
            pend_job_reg <= job2;
    end

endmodule
`default_nettype wire

/* rtl/scbc_queue.sv */
`default_nettype none
// ============================================================================
// scbc_queue - short job queue between the front and the back
// A small register FIFO that lets either side stall on its own.
// ============================================================================
module scbc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);
    import scbc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

/* rtl/scbc_back.sv */
`default_nettype none
// ============================================================================
// scbc_back - control point arithmetic and Bezier point emitter
// Multiplies differences by k, rounds offsets toward zero, adds and saturates
// the control points, then sends the segment one point a cycle while ready.
// ============================================================================
module scbc_back #(
    parameter int COORD_BITS = 16,
    localparam int JOB_W = scbc_pkg::job_width(COORD_BITS)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [scbc_pkg::K_BITS-1:0]  k,
    input  wire logic                         job_valid,
    output logic                              job_ready,
    input  wire logic [JOB_W-1:0]             job_in,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS-1:0]      out_x,
    output logic signed [COORD_BITS-1:0]      out_y,
    output scbc_pkg::point_kind_t             out_kind,
    output logic                              out_last,
    output logic                              out_done
);
    import scbc_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int PROD_W = CB + K_BITS + 2;
    localparam int OFF_W  = CB + 1;

    typedef struct packed {
        seg_flags_t            flags;
        logic signed [CB:0]    dby;
        logic signed [CB:0]    dbx;
        logic signed [CB:0]    day;
        logic signed [CB:0]    dax;
        logic signed [CB-1:0]  p2y;
        logic signed [CB-1:0]  p2x;
        logic signed [CB-1:0]  p1y;
        logic signed [CB-1:0]  p1x;
    } job_t;

    typedef enum logic [2:0] {
        EM_IDLE,
        EM_ANCHOR,
        EM_CTRL1,
        EM_CTRL2,
        EM_END
    } emit_state_t;

    // Adds one half and truncates toward zero.
    function automatic logic signed [OFF_W-1:0] round_off(
        input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        logic signed [OFF_W-1:0]  q;
        s = p + $signed(PROD_W'(ROUND_HALF));
        q = s[FRAC_BITS +: OFF_W];
        if (s[PROD_W-1] && (s[FRAC_BITS-1:0] != '0))
            q = q + OFF_W'(1);
        return q;
    endfunction

    function automatic logic signed [CB-1:0] sat(input logic signed [CB+1:0] v);
        logic signed [CB-1:0] r;
        if ((v[CB+1:CB-1] == 3'b000) || (v[CB+1:CB-1] == 3'b111))
            r = v[CB-1:0];
        else if (v[CB+1])
            r = {1'b1, {(CB-1){1'b0}}};
        else
            r = {1'b0, {(CB-1){1'b1}}};
        return r;
    endfunction

    job_t                     job;
    logic signed [K_BITS:0]   k_s;

    // Multiply stage.
    logic                     m_valid_reg;
    logic signed [PROD_W-1:0] m_ax_reg;
    logic signed [PROD_W-1:0] m_ay_reg;
    logic signed [PROD_W-1:0] m_bx_reg;
    logic signed [PROD_W-1:0] m_by_reg;
    logic signed [CB-1:0]     m_p1x_reg;
    logic signed [CB-1:0]     m_p1y_reg;
    logic signed [CB-1:0]     m_p2x_reg;
    logic signed [CB-1:0]     m_p2y_reg;
    seg_flags_t               m_flags_reg;

    // Offset stage.
    logic                     o_valid_reg;
    logic signed [OFF_W-1:0]  o_ax_reg;
    logic signed [OFF_W-1:0]  o_ay_reg;
    logic signed [OFF_W-1:0]  o_bx_reg;
    logic signed [OFF_W-1:0]  o_by_reg;
    logic signed [CB-1:0]     o_p1x_reg;
    logic signed [CB-1:0]     o_p1y_reg;
    logic signed [CB-1:0]     o_p2x_reg;
    logic signed [CB-1:0]     o_p2y_reg;
    seg_flags_t               o_flags_reg;

    // Segment buffer read by the emitter.
    logic signed [CB-1:0]     s_p1x_reg;
    logic signed [CB-1:0]     s_p1y_reg;
    logic signed [CB-1:0]     s_p2x_reg;
    logic signed [CB-1:0]     s_p2y_reg;
    logic signed [CB-1:0]     s_c1x_reg;
    logic signed [CB-1:0]     s_c1y_reg;
    logic signed [CB-1:0]     s_c2x_reg;
    logic signed [CB-1:0]     s_c2y_reg;
    seg_flags_t               s_flags_reg;

    emit_state_t              state_reg;
    emit_state_t              state_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [CB-1:0]     out_x_reg;
    logic signed [CB-1:0]     out_x_next;
    logic signed [CB-1:0]     out_y_reg;
    logic signed [CB-1:0]     out_y_next;
    point_kind_t              out_kind_reg;
    point_kind_t              out_kind_next;
    logic                     out_last_reg;
    logic                     out_last_next;
    logic                     out_done_reg;
    logic                     out_done_next;

    logic                     out_load;
    logic                     seg_free;
    logic                     s_load;
    logic                     o_ready;
    logic                     m_ready;

    assign job = job_t'(job_in);
    assign k_s = $signed({1'b0, k});

    assign out_load  = (state_reg != EM_IDLE) && (!out_valid_reg || out_ready);
    assign seg_free  = (state_reg == EM_IDLE) || (out_load && (state_reg == EM_END));
    assign s_load    = o_valid_reg && seg_free;
    assign o_ready   = !o_valid_reg || seg_free;
    assign m_ready   = !m_valid_reg || o_ready;
    assign job_ready = m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= (job_valid && m_ready) || (m_valid_reg && !o_ready);
            o_valid_reg <= (m_valid_reg && o_ready) || (o_valid_reg && !seg_free);
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && m_ready)
        begin
            m_ax_reg    <= k_s * job.dax;
            m_ay_reg    <= k_s * job.day;
            m_bx_reg    <= k_s * job.dbx;
            m_by_reg    <= k_s * job.dby;
            m_p1x_reg   <= job.p1x;
            m_p1y_reg   <= job.p1y;
            m_p2x_reg   <= job.p2x;
            m_p2y_reg   <= job.p2y;
            m_flags_reg <= job.flags;
        end
        if (m_valid_reg && o_ready)
        begin
            o_ax_reg    <= round_off(m_ax_reg);
            o_ay_reg    <= round_off(m_ay_reg);
            o_bx_reg    <= round_off(m_bx_reg);
            o_by_reg    <= round_off(m_by_reg);
            o_p1x_reg   <= m_p1x_reg;
            o_p1y_reg   <= m_p1y_reg;
            o_p2x_reg   <= m_p2x_reg;
            o_p2y_reg   <= m_p2y_reg;
            o_flags_reg <= m_flags_reg;
        end
        if (s_load)
        begin
            s_p1x_reg   <= o_p1x_reg;
            s_p1y_reg   <= o_p1y_reg;
            s_p2x_reg   <= o_p2x_reg;
            s_p2y_reg   <= o_p2y_reg;
            s_c1x_reg   <= sat({{2{o_p1x_reg[CB-1]}}, o_p1x_reg} + {o_ax_reg[CB], o_ax_reg});
            s_c1y_reg   <= sat({{2{o_p1y_reg[CB-1]}}, o_p1y_reg} + {o_ay_reg[CB], o_ay_reg});
            s_c2x_reg   <= sat({{2{o_p2x_reg[CB-1]}}, o_p2x_reg} - {o_bx_reg[CB], o_bx_reg});
            s_c2y_reg   <= sat({{2{o_p2y_reg[CB-1]}}, o_p2y_reg} - {o_by_reg[CB], o_by_reg});
            s_flags_reg <= o_flags_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b0;
            out_done_next  = 1'b0;
            unique case (state_reg)
                EM_ANCHOR:
                begin
                    out_x_next    = s_p1x_reg;
                    out_y_next    = s_p1y_reg;
                    out_kind_next = KIND_ANCHOR;
                    state_next    = EM_CTRL1;
                end
                EM_CTRL1:
                begin
                    out_x_next    = s_c1x_reg;
                    out_y_next    = s_c1y_reg;
                    out_kind_next = KIND_CTRL1;
                    state_next    = EM_CTRL2;
                end
                EM_CTRL2:
                begin
                    out_x_next    = s_c2x_reg;
                    out_y_next    = s_c2y_reg;
                    out_kind_next = KIND_CTRL2;
                    state_next    = EM_END;
                end
                EM_END:
                begin
                    out_x_next    = s_p2x_reg;
                    out_y_next    = s_p2y_reg;
                    out_kind_next = KIND_END;
                    out_last_next = s_flags_reg.run_last;
                    out_done_next = s_flags_reg.done;
                    state_next    = EM_IDLE;
                end
                default:
                begin
                    state_next = EM_IDLE;
                end
            endcase
        end
        if (s_load)
            state_next = o_flags_reg.anchor ? EM_ANCHOR : EM_CTRL1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EM_IDLE;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_kind_reg  <= KIND_ANCHOR;
            out_last_reg  <= 1'b0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_kind_reg  <= out_kind_next;
            out_last_reg  <= out_last_next;
            out_done_reg  <= out_done_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;
    assign out_done  = out_done_reg;

endmodule
`default_nettype wire

/* rtl/spline_to_bezier_converter_core.sv */
`default_nettype none
// ============================================================================
// spline_to_bezier_converter_core - Catmull-Rom polyline to cubic Bezier
// Streams polyline points in and chained cubic Bezier points out.
// ============================================================================
//
// Points arrive one item at a time on the s_ side, with s_tlast on the final
// point of a curve. Each segment leaves on the m_ side as first control,
// second control and end point; the first segment of a curve is preceded by
// its start anchor. The end point stands in for a missing neighbour. The
// control offsets are k times the neighbour difference, rounded by adding one
// half and truncating toward zero, and all coordinates saturate to
// COORD_BITS. A curve of a single point produces nothing. m_tlast marks the
// last result of each input item, m_tuser[2] the last result of the curve.
// The result channel carries one point a cycle while m_tready is high, and
// that emitter sets the rate. A final point after two or more points makes
// two segments and holds the input until the second one is queued. A
// point's first result is registered in the queue, then in the multiply,
// rounding, saturation and output registers. A four-entry queue between the
// classifier and the arithmetic lets the input run ahead while the output is
// stalled. The tension register clamps values above 21845 when written and
// may only be written while idle.
//
module spline_to_bezier_converter_core #(
    parameter int COORD_BITS = 16,
    localparam int DATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [DATA_W-1:0]            s_tdata,   // point_x, point_y
    input  wire logic                         s_tlast,   // final_point
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [DATA_W-1:0]                 m_tdata,   // out_x, out_y
    output logic                              m_tlast,   // run_last
    output logic [scbc_pkg::USER_W-1:0]       m_tuser,   // point_kind, curve_done
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [scbc_pkg::K_BITS-1:0]  cfg_data   // tension_k
);
    import scbc_pkg::*;

    localparam int JOB_W = job_width(COORD_BITS);
    localparam int QUEUE_DEPTH = 4;

    logic [K_BITS-1:0]            tension_reg;
    logic [K_BITS-1:0]            tension_next;

    logic                         push_valid;
    logic                         push_ready;
    logic [JOB_W-1:0]             push_job;
    logic                         pop_valid;
    logic                         pop_ready;
    logic [JOB_W-1:0]             pop_job;

    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    point_kind_t                  out_kind;
    logic                         out_done;

    // The register is always ready; oversized tension is clamped on write.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        tension_next = tension_reg;
        if (cfg_valid && cfg_ready)
            tension_next = (cfg_data > K_MAX) ? K_MAX : cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tension_reg <= K_RESET;
        else
            tension_reg <= tension_next;
    end

    scbc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_x       ($signed(s_tdata[COORD_BITS-1:0])),
        .in_y       ($signed(s_tdata[2*COORD_BITS-1:COORD_BITS])),
        .in_final   (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    scbc_queue #(
        .WIDTH      (JOB_W),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_job)
    );

    scbc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .k          (tension_reg),
        .job_valid  (pop_valid),
        .job_ready  (pop_ready),
        .job_in     (pop_job),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_kind   (out_kind),
        .out_last   (m_tlast),
        .out_done   (out_done)
    );

    // Coordinates packed x low, y high, zero filled to whole bytes.
    assign m_tdata = DATA_W'({out_y, out_x});
    assign m_tuser = {out_done, out_kind};

`ifndef SYNTHESIS
    // The end of a curve is always also the end of its item's results.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_done |-> m_tlast)
        else $error("curve_done raised without run_last");

    // Only segment end points close the results of an item.
    a_last_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (out_kind == KIND_END))
        else $error("run_last on a point that is not a segment end");

    // The stored tension never leaves its legal range.
    a_tension_range: assert property (@(posedge clk) disable iff (!rst_n)
        tension_reg <= K_MAX)
        else $error("tension register above its maximum");
`endif

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench - self-checking bench for spline_to_bezier_converter_core
// Streams polylines into the converter and tracks the expected chained
// Bezier points in a scoreboard. Every result item is compared field by
// field. Both stream sides pause at random, and the tension register is
// rewritten while the block is idle.
// ============================================================================
module testbench;

    localparam int CW             = 16;
    localparam int DW             = 32;
    localparam int SETTLE_CYCLES  = 20;    // latency margin before an idle write
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
    localparam int ITEM_TARGET    = 410;

    // One Bezier point as it leaves the block.
    typedef struct {
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        scbc_pkg::point_kind_t kind;
        logic                  run_last;
        logic                  done;
    } bez_point_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the point window and the tension setting, turns
    // each accepted polyline point into the Bezier points it should cause,
    // and compares the results in order.
    // ------------------------------------------------------------------------
    class bezier_tracker;
        localparam longint TENSION_CAP = 21845;
        localparam longint HALF_LSB    = 32768;
        localparam longint ONE_Q16     = 65536;

        longint           win_x [3];
        longint           win_y [3];
        int unsigned      seen;
        logic [14:0]      tension;
        bez_point_t       bezier_due [$];
        bez_point_t       batch [$];
        int               errors;
        int               matched;
        int               curves;

        function new();
            for (int i = 0; i < 3; i++)
            begin
                win_x[i] = 0;
                win_y[i] = 0;
            end
            seen    = 0;
            tension = scbc_pkg::K_RESET;
            errors  = 0;
            matched = 0;
            curves  = 0;
        endfunction

        function void set_tension(logic [14:0] value);
            tension = value;
        endfunction

        function int pending();
            return bezier_due.size();
        endfunction

        // Control offset: k * diff plus one half, truncated toward zero.
        function longint tangent_offset(longint diff);
            longint k;
            k = (longint'(tension) > TENSION_CAP) ? TENSION_CAP : longint'(tension);
            return (k * diff + HALF_LSB) / ONE_Q16;
        endfunction

        function longint clip(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        function void add(longint x, longint y, scbc_pkg::point_kind_t kind);
            bez_point_t t;
            t.x        = x[CW-1:0];
            t.y        = y[CW-1:0];
            t.kind     = kind;
            t.run_last = 1'b0;
            t.done     = 1'b0;
            batch = {batch, t};
        endfunction

        // One Catmull-Rom segment from p1 to p2, with p0 and p3 as neighbours.
        function void add_segment(longint x0, longint y0, longint x1, longint y1,
                                  longint x2, longint y2, longint x3, longint y3,
                                  bit anchor);
            if (anchor)
                add(x1, y1, scbc_pkg::KIND_ANCHOR);
            add(clip(x1 + tangent_offset(x2 - x0)), clip(y1 + tangent_offset(y2 - y0)),
                scbc_pkg::KIND_CTRL1);
            add(clip(x2 - tangent_offset(x3 - x1)), clip(y2 - tangent_offset(y3 - y1)),
                scbc_pkg::KIND_CTRL2);
            add(x2, y2, scbc_pkg::KIND_END);
        endfunction

        function void take_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                 logic fin);
            longint     dx;
            longint     dy;
            longint     ax;
            longint     ay;
            bez_point_t t;
            dx = longint'(px);
            dy = longint'(py);
            batch.delete();
            if (seen == 1)
            begin
                // A two-point curve repeats its end points as both neighbours.
                if (fin)
                    add_segment(win_x[2], win_y[2], win_x[2], win_y[2], dx, dy, dx, dy, 1'b1);
            end
            else if (seen >= 2)
            begin
                ax = (seen == 2) ? win_x[1] : win_x[0];
                ay = (seen == 2) ? win_y[1] : win_y[0];
                add_segment(ax, ay, win_x[1], win_y[1], win_x[2], win_y[2], dx, dy,
                            seen == 2);
                if (fin)
                    add_segment(win_x[1], win_y[1], win_x[2], win_y[2], dx, dy, dx, dy,
                                1'b0);
            end
            win_x[0] = win_x[1];
            win_y[0] = win_y[1];
            win_x[1] = win_x[2];
            win_y[1] = win_y[2];
            win_x[2] = dx;
            win_y[2] = dy;
            if (fin)
            begin
                seen = 0;
                curves++;
            end
            else if (seen < 3)
            begin
                seen++;
            end
            if (batch.size() > 0)
            begin
                t          = batch[batch.size() - 1];
                t.run_last = 1'b1;
                t.done     = fin;
                batch[batch.size() - 1] = t;
            end
            bezier_due = {bezier_due, batch};
        endfunction

        function void report_field(string name, longint want, longint got);
            errors++;
            $display("%0t: mismatch in %s, expected %0d, actual %0d",
                     $time, name, want, got);
        endfunction

        function void check_point(bez_point_t got);
            bez_point_t want;
            if (bezier_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result item, expected none, actual x=%0d y=%0d kind=%0d",
                         $time, got.x, got.y, got.kind);
                return;
            end
            want = bezier_due.pop_front();
            matched++;
            if (got.x !== want.x)
                report_field("out_x", want.x, got.x);
            if (got.y !== want.y)
                report_field("out_y", want.y, got.y);
            if (got.kind !== want.kind)
                report_field("point_kind", want.kind, got.kind);
            if (got.run_last !== want.run_last)
                report_field("run_last", want.run_last, got.run_last);
            if (got.done !== want.done)
                report_field("curve_done", want.done, got.done);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [DW-1:0]                 s_tdata   = '0;
    logic                          s_tlast   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [DW-1:0]                 m_tdata;
    logic                          m_tlast;
    logic [scbc_pkg::USER_W-1:0]   m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [scbc_pkg::K_BITS-1:0]   cfg_data  = '0;

    bezier_tracker sb;
    bit            calm          = 1'b0;  // no idling on either side while set
    int            points_sent   = 0;
    int            tension_writes = 0;
    int            idle_cycles   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    spline_to_bezier_converter_core #(
        .COORD_BITS (CW)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // point_x, point_y
        .s_tlast   (s_tlast),    // final_point
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // out_x, out_y
        .m_tlast   (m_tlast),    // run_last
        .m_tuser   (m_tuser),    // point_kind, curve_done
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)    // tension_k
    );

    // Sender gap: usually none, sometimes a few cycles, rarely a long pause.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver stall length, never zero.
    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    // Coordinates lean on the extremes and on small values, where the rounding
    // toward zero matters, with full-range values for the rest.
    function automatic logic signed [CW-1:0] rand_coord();
        int r;
        int s;
        r = $urandom_range(0, 9);
        s = $urandom_range(0, 100);
        case (r) inside
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3, 4: return CW'(s - 50);
            default: return CW'($urandom);
        endcase
    endfunction

    // Tension choices include zero, the cap, values above the cap and values in range.
    function automatic logic [14:0] pick_tension();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 15'd0;
            1:       return 15'd21845;
            2:       return 15'h7FFF;
            3:       return 15'($urandom_range(21846, 32767));
            default: return 15'($urandom_range(0, 21845));
        endcase
    endfunction

    // Offer one polyline point and hold it until the block takes it. The valid
    // stays high on return so a back-to-back item never drops it.
    task automatic send_point(input logic signed [CW-1:0] px,
                              input logic signed [CW-1:0] py, input logic fin);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        points_sent++;
    endtask

    // Stop sending, wait for every expected point, then let the pipe settle.
    // The first edge lets the monitor note the item taken at the current one.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tension(input logic [14:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tension_writes++;
    endtask

    // Result side: ready in runs of random length broken by stalls, and held
    // high in a calm stretch once any stall under way has run out.
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                hold = 0;
            end
            else if (hold != 0)
            begin
                hold--;
            end
            else if (!m_tready || calm)
            begin
                m_tready <= 1'b1;
                hold = calm ? 0 : $urandom_range(0, 12);
            end
            else
            begin
                m_tready <= 1'b0;
                hold = stall_len() - 1;
            end
        end
    end

    // Monitor and watchdog. Signals are sampled at the edge, before any
    // nonblocking update of that step, so handshakes are seen as the block
    // sees them.
    always @(posedge clk)
    begin
        bez_point_t got;
        bit         moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                sb.set_tension(cfg_data);
                moved = 1'b1;
            end
            if (s_tvalid && s_tready)
            begin
                sb.take_point(s_tdata[CW-1:0], s_tdata[2*CW-1:CW], s_tlast);
                moved = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                got.x        = m_tdata[CW-1:0];
                got.y        = m_tdata[2*CW-1:CW];
                got.kind     = scbc_pkg::point_kind_t'(m_tuser[1:0]);
                got.run_last = m_tlast;
                got.done     = m_tuser[2];
                sb.check_point(got);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d points still expected",
                         $time, WATCHDOG_LIMIT, sb.pending());
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: a directed opening, then random curves with tension changes.
    // ------------------------------------------------------------------------
    initial
    begin
        int  len;
        int  r;
        int  next_write;
        bit  paused;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A lone final point starts and ends a curve with no output.
        send_point(16'sd100, -16'sd200, 1'b1);
        // Two-point curve at the coordinate extremes, reset tension.
        send_point(16'sh8000, 16'sh8000, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
        // A final third point emits the anchor and two segments at once.
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd1000, -16'sd1000, 1'b0);
        send_point(-16'sd5, 16'sd5, 1'b1);

        // Zero tension: the controls sit on the polyline points.
        write_tension(15'd0);
        send_point(16'sh8000, 16'sh8000, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(16'sh8000, 16'sh8000, 1'b1);

        // Full tension on the same curve drives the controls into saturation.
        write_tension(15'd21845);
        send_point(16'sh8000, 16'sh8000, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(16'sh8000, 16'sh8000, 1'b1);

        // A tension above the cap must behave as the cap. Small steps of both
        // signs check that rounding truncates toward zero, and the five-point
        // curve runs the point count into saturation.
        write_tension(15'h7FFF);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd3, -16'sd3, 1'b0);
        send_point(-16'sd3, 16'sd3, 1'b0);
        send_point(16'sd1, -16'sd1, 1'b0);
        send_point(16'sd2, 16'sd2, 1'b1);

        // Smallest nonzero tension with opposite extremes.
        write_tension(15'd1);
        send_point(16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, 16'sh8000, 1'b1);

        write_tension(pick_tension());

        // Random curves, mostly long enough to reach the steady state, with
        // single and two-point curves mixed in.
        next_write = points_sent + $urandom_range(60, 100);
        paused     = 1'b0;
        while (points_sent < ITEM_TARGET)
        begin
            if (points_sent >= next_write)
            begin
                write_tension(pick_tension());
                next_write = points_sent + $urandom_range(60, 100);
            end
            calm = (points_sent >= 150 && points_sent < 210);
            r = $urandom_range(0, 99);
            if (r < 8)
                len = 1;
            else if (r < 20)
                len = 2;
            else if (r < 30)
                len = 3;
            else
                len = $urandom_range(4, 12);
            for (int i = 0; i < len; i++)
            begin
                send_point(rand_coord(), rand_coord(), i == len - 1);
                // Once, hold the sender mid-curve until the output has caught up.
                if (!paused && points_sent >= 260 && i == 1 && len > 3)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end
        calm = 1'b0;

        wait_drained();

        $display("Sent %0d points in %0d curves, checked %0d Bezier points.",
                 points_sent, sb.curves, sb.matched);
        $display("Tension was rewritten %0d times, covering zero, the cap and above.",
                 tension_writes);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("%0d mismatches, %0d points never arrived", sb.errors, sb.pending());
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

/* spline_to_bezier_converter_core.f */
rtl/scbc_pkg.sv
rtl/scbc_front.sv
rtl/scbc_queue.sv
rtl/scbc_back.sv
rtl/spline_to_bezier_converter_core.sv
dv/testbench.sv
